// File: rtl/lsmt_pkg.sv
// shared types and constants for the laser scan motion target block
package lsmt_pkg;

  localparam int RANGE_W = 16;
  localparam int BEAM_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HIST_W  = 3;
  localparam int MOVE_MIN = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FIRST_BEAM = 2'd0;
  localparam cfg_idx_t CFG_LAST_BEAM  = 2'd1;
  localparam cfg_idx_t CFG_CHANGE_THR = 2'd2;
  localparam cfg_idx_t CFG_NEAR_LIMIT = 2'd3;

  localparam logic [BEAM_W-1:0]  FIRST_BEAM_RST = 10'd85;
  localparam logic [BEAM_W-1:0]  LAST_BEAM_RST  = 10'd594;
  localparam logic [RANGE_W-1:0] CHANGE_THR_RST = 16'd100;
  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 16'd500;

endpackage

// File: rtl/lsmt_if.sv
// valid/ready channel interfaces for range samples and scan results
interface lsmt_in_if;
  import lsmt_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               last_in_scan;

  modport source (output valid, output range_mm, output last_in_scan, input ready);
  modport sink   (input valid, input range_mm, input last_in_scan, output ready);
endinterface

interface lsmt_out_if;
  import lsmt_pkg::*;
  logic              valid;
  logic              ready;
  logic              moving;
  logic              scan_done;
  logic              path_free;
  logic              target_found;
  logic [BEAM_W-1:0] target_beam;

  modport source (output valid, output moving, output scan_done, output path_free,
                  output target_found, output target_beam, input ready);
  modport sink   (input valid, input moving, input scan_done, input path_free,
                  input target_found, input target_beam, output ready);
endinterface

// File: rtl/laser_scan_motion_target_core.sv
// laser scan background change detector with reference range memory
// pipeline: a sample word is registered into stage 1, and its result word into the output register
// throughput: one word per cycle while the result channel takes words, set by one reference memory read per beam
// plus the compare and update stage that follows it
// reset (synchronous, rst_n low) clears control, scan state and config to defaults;
// the reference memory is not cleared, samples in the window fill it until the last window beam arrives
module laser_scan_motion_target_core
  import lsmt_pkg::*;
#(
  parameter int MAX_BEAMS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lsmt_in_if.sink               in_ch,
  lsmt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDXW = $clog2(MAX_BEAMS);
  localparam int CMPW = (IDXW > BEAM_W) ? IDXW : BEAM_W;
  localparam int DIFW = CMPW + 1;

  // config registers
  logic [BEAM_W-1:0]  first_beam_r, last_beam_r;
  logic [RANGE_W-1:0] change_thr_r, near_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_beam_r <= FIRST_BEAM_RST;
      last_beam_r  <= LAST_BEAM_RST;
      change_thr_r <= CHANGE_THR_RST;
      near_limit_r <= NEAR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_BEAM: first_beam_r <= cfg_wdata[BEAM_W-1:0];
        CFG_LAST_BEAM:  last_beam_r  <= cfg_wdata[BEAM_W-1:0];
        CFG_CHANGE_THR: change_thr_r <= cfg_wdata[RANGE_W-1:0];
        CFG_NEAR_LIMIT: near_limit_r <= cfg_wdata[RANGE_W-1:0];
      endcase
    end
  end

  // handshake
  logic s1_valid_r, out_valid_r;
  logic out_free, s1_fire, in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // stage 0: beam index and memory read address
  logic [IDXW-1:0] beam_cnt_r, beam_cnt_nxt;
  logic            in_win;

  always_comb begin
    if (in_ch.last_in_scan || beam_cnt_r == IDXW'(MAX_BEAMS - 1)) begin
      beam_cnt_nxt = '0;
    end else begin
      beam_cnt_nxt = beam_cnt_r + 1'b1;
    end
  end

  assign in_win = (CMPW'(beam_cnt_r) >= CMPW'(first_beam_r)) &&
                  (CMPW'(beam_cnt_r) <= CMPW'(last_beam_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_cnt_r <= '0;
    end else if (in_fire) begin
      beam_cnt_r <= beam_cnt_nxt;
    end
  end

  // stage 1 registers
  logic [IDXW-1:0]    s1_idx_r;
  logic [RANGE_W-1:0] s1_range_r;
  logic               s1_last_r, s1_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r   <= beam_cnt_r;
      s1_range_r <= in_ch.range_mm;
      s1_last_r  <= in_ch.last_in_scan;
      s1_win_r   <= in_win;
    end
  end

  // reference memory with write-to-read forwarding
  logic [RANGE_W-1:0] ref_mem [MAX_BEAMS];
  logic [RANGE_W-1:0] ref_rd_r, fwd_data_r, ref_val;
  logic               fwd_hit_r;
  logic               ref_ready_r, ref_ready_nxt;
  logic               mem_we;

  assign mem_we = s1_fire && s1_win_r && !ref_ready_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[s1_idx_r] <= s1_range_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ref_rd_r <= ref_mem[beam_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= mem_we && (s1_idx_r == beam_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= s1_range_r;
    end
  end

  assign ref_val = fwd_hit_r ? fwd_data_r : ref_rd_r;

  // stage 1: compare and scan state update
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic              have_mv_r, have_mv_nxt;
  logic [IDXW-1:0]   first_mv_r, first_mv_nxt, last_mv_r, last_mv_nxt;
  logic              free_r, free_nxt;
  logic [RANGE_W-1:0] abs_diff;
  logic              mark, moving;
  logic [DIFW-1:0]   mid_diff, mid_sum;

  always_comb begin
    abs_diff = (ref_val > s1_range_r) ? (ref_val - s1_range_r) : (s1_range_r - ref_val);
    mark     = s1_win_r && ref_ready_r && (abs_diff > change_thr_r);
    moving   = s1_win_r && ($countones({mark, hist_r}) >= MOVE_MIN);

    ref_ready_nxt = ref_ready_r;
    if (s1_win_r && !ref_ready_r && (CMPW'(s1_idx_r) == CMPW'(last_beam_r))) begin
      ref_ready_nxt = 1'b1;
    end

    free_nxt = free_r;
    if (s1_win_r && (s1_range_r < near_limit_r)) begin
      free_nxt = 1'b0;
    end

    have_mv_nxt  = have_mv_r;
    first_mv_nxt = first_mv_r;
    last_mv_nxt  = last_mv_r;
    if (moving) begin
      if (!have_mv_r) begin
        first_mv_nxt = s1_idx_r;
      end
      have_mv_nxt = 1'b1;
      last_mv_nxt = s1_idx_r;
    end

    hist_nxt = {hist_r[HIST_W-2:0], mark};

    mid_diff = DIFW'(last_mv_nxt) - DIFW'(first_mv_nxt);
    mid_sum  = (mid_diff >> 1) + DIFW'(first_mv_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ready_r <= 1'b0;
      hist_r      <= '0;
      have_mv_r   <= 1'b0;
      first_mv_r  <= '0;
      last_mv_r   <= '0;
      free_r      <= 1'b1;
    end else if (s1_fire) begin
      ref_ready_r <= ref_ready_nxt;
      if (s1_last_r) begin
        hist_r     <= '0;
        have_mv_r  <= 1'b0;
        first_mv_r <= '0;
        last_mv_r  <= '0;
        free_r     <= 1'b1;
      end else begin
        hist_r     <= hist_nxt;
        have_mv_r  <= have_mv_nxt;
        first_mv_r <= first_mv_nxt;
        last_mv_r  <= last_mv_nxt;
        free_r     <= free_nxt;
      end
    end
  end

  // output register
  logic              o_moving_r, o_done_r, o_free_r, o_found_r;
  logic [BEAM_W-1:0] o_beam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_moving_r <= moving;
      o_done_r   <= s1_last_r;
      o_free_r   <= s1_last_r && free_nxt;
      o_found_r  <= s1_last_r && have_mv_nxt;
      o_beam_r   <= (s1_last_r && have_mv_nxt) ? mid_sum[BEAM_W-1:0] : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.moving       = o_moving_r;
  assign out_ch.scan_done    = o_done_r;
  assign out_ch.path_free    = o_free_r;
  assign out_ch.target_found = o_found_r;
  assign out_ch.target_beam  = o_beam_r;

endmodule

// File: rtl/lsmt_checker.sv
// port-level assertions for the laser scan motion target core and their bind
module lsmt_checker
  import lsmt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_moving,
  input logic              out_scan_done,
  input logic              out_path_free,
  input logic              out_target_found,
  input logic [BEAM_W-1:0] out_target_beam
);

  // result channel empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_moving) &&
      $stable(out_scan_done) && $stable(out_path_free) &&
      $stable(out_target_found) && $stable(out_target_beam))
    else $error("stalled result word changed");

  // scan summary fields only at scan end
  a_summary_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scan_done |-> !out_path_free && !out_target_found &&
      out_target_beam == '0)
    else $error("scan summary outside scan end");

  // no target means zero target beam
  a_no_target_beam: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_target_found |-> out_target_beam == '0)
    else $error("target beam set without target");

endmodule

bind laser_scan_motion_target_core lsmt_checker u_lsmt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_moving       (out_ch.moving),
  .out_scan_done    (out_ch.scan_done),
  .out_path_free    (out_ch.path_free),
  .out_target_found (out_ch.target_found),
  .out_target_beam  (out_ch.target_beam)
);

// File: verif/testbench.sv
// testbench for laser_scan_motion_target_core: directed and random range scans checked by a scan predictor
`timescale 1ns / 1ps

module testbench;
  import lsmt_pkg::*;

  typedef struct packed {
    logic              moving;
    logic              scan_done;
    logic              path_free;
    logic              target_found;
    logic [BEAM_W-1:0] target_beam;
  } scan_report_t;

  class motion_scoreboard;
    bit [BEAM_W-1:0]  first_beam;
    bit [BEAM_W-1:0]  last_beam;
    bit [RANGE_W-1:0] change_thr;
    bit [RANGE_W-1:0] near_limit;
    bit [RANGE_W-1:0] background_mm [2**BEAM_W];
    bit               background_ready;
    bit [BEAM_W-1:0]  beam_idx;
    bit [HIST_W-1:0]  marks;
    bit               have_moving;
    bit [BEAM_W-1:0]  first_mov;
    bit [BEAM_W-1:0]  last_mov;
    bit               free_so_far;
    scan_report_t     expected_reports [$];
    int unsigned      failures;

    function void start_scan();
      beam_idx    = '0;
      marks       = '0;
      have_moving = 1'b0;
      first_mov   = '0;
      last_mov    = '0;
      free_so_far = 1'b1;
    endfunction

    function void power_on();
      first_beam       = FIRST_BEAM_RST;
      last_beam        = LAST_BEAM_RST;
      change_thr       = CHANGE_THR_RST;
      near_limit       = NEAR_LIMIT_RST;
      background_ready = 1'b0;
      failures         = 0;
      start_scan();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FIRST_BEAM: first_beam = val[BEAM_W-1:0];
        CFG_LAST_BEAM:  last_beam  = val[BEAM_W-1:0];
        CFG_CHANGE_THR: change_thr = val[RANGE_W-1:0];
        CFG_NEAR_LIMIT: near_limit = val[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [RANGE_W-1:0] background_at(int unsigned idx);
      return background_mm[idx];
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void note_sample(logic [RANGE_W-1:0] range_mm, logic last);
      bit [BEAM_W-1:0]  idx;
      bit               in_win;
      bit               mark;
      bit               mov;
      bit [RANGE_W-1:0] diff;
      scan_report_t     rep;
      idx    = beam_idx;
      in_win = (idx >= first_beam) && (idx <= last_beam);
      mark   = 1'b0;
      mov    = 1'b0;
      if (in_win) begin
        if (range_mm < near_limit) free_so_far = 1'b0;
        if (!background_ready) begin
          background_mm[idx] = range_mm;
          if (idx == last_beam) background_ready = 1'b1;
        end else begin
          diff = (background_mm[idx] > range_mm) ? background_mm[idx] - range_mm
                                                 : range_mm - background_mm[idx];
          mark = diff > change_thr;
        end
        mov = $countones({mark, marks}) >= MOVE_MIN;
        if (mov) begin
          if (!have_moving) begin
            first_mov   = idx;
            have_moving = 1'b1;
          end
          last_mov = idx;
        end
      end
      marks = {marks[HIST_W-2:0], mark};
      rep = '0;
      rep.moving    = mov;
      rep.scan_done = last;
      if (last) begin
        rep.path_free = free_so_far;
        if (have_moving) begin
          rep.target_found = 1'b1;
          rep.target_beam  = ((last_mov - first_mov) >> 1) + first_mov;
        end
        start_scan();
      end else begin
        beam_idx = idx + 1'b1;
      end
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [BEAM_W-1:0] want, logic [BEAM_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_report(scan_report_t got);
      scan_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, got);
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("moving", want.moving, got.moving);
      compare_field("scan_done", want.scan_done, got.scan_done);
      compare_field("path_free", want.path_free, got.path_free);
      compare_field("target_found", want.target_found, got.target_found);
      compare_field("target_beam", want.target_beam, got.target_beam);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsmt_in_if  in_ch ();
  lsmt_out_if out_ch ();

  motion_scoreboard board;
  bit in_gaps       = 1'b1;
  bit out_gaps      = 1'b1;
  bit stall_request = 1'b0;

  laser_scan_motion_target_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #400000;
    $display("** laser_scan_motion_target_core: FAILED **");
    $finish;
  end

  // valid stays high across back-to-back words
  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic last);
    while (in_gaps && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.range_mm     <= r;
    in_ch.last_in_scan <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(r, last);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [BEAM_W-1:0] fb, input logic [BEAM_W-1:0] lb,
                              input logic [RANGE_W-1:0] thr, input logic [RANGE_W-1:0] near);
    cfg_idx_t              order [4];
    logic [CFG_DATA_W-1:0] vals  [4];
    int                    i;
    order = '{CFG_FIRST_BEAM, CFG_LAST_BEAM, CFG_CHANGE_THR, CFG_NEAR_LIMIT};
    vals[0] = {6'($urandom_range(63)), fb};
    vals[1] = {6'($urandom_range(63)), lb};
    vals[2] = thr;
    vals[3] = near;
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // range at distance d from the background, either side where it fits, else a random range
  function automatic logic [RANGE_W-1:0] shifted(logic [RANGE_W-1:0] bg, int unsigned d);
    int unsigned b;
    b = bg;
    if (b + d <= 65535 && (b < d || $urandom_range(1) == 1)) return RANGE_W'(b + d);
    if (b >= d) return RANGE_W'(b - d);
    return RANGE_W'($urandom_range(65535));
  endfunction

  // unchanged beams around one run of changed beams, plus some noise
  task automatic send_scan(input int unsigned beams, input logic [RANGE_W-1:0] thr);
    int unsigned      run_lo;
    int unsigned      run_hi;
    int unsigned      roll;
    int unsigned      d;
    int unsigned      k;
    logic [RANGE_W-1:0] r;
    run_lo = $urandom_range(0, beams - 1);
    run_hi = run_lo + $urandom_range(0, 12);
    for (k = 0; k < beams; k++) begin
      roll = $urandom_range(99);
      if (k >= run_lo && k <= run_hi) d = thr + 1 + ((roll < 30) ? 0 : $urandom_range(2000));
      else if (roll < 20) d = thr;
      else d = $urandom_range(thr);
      r = (roll < 6) ? RANGE_W'($urandom_range(65535)) : shifted(board.background_at(k), d);
      send_sample(r, k == beams - 1);
    end
  endtask

  initial begin : result_sink
    int unsigned  hold_left;
    scan_report_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = {out_ch.moving, out_ch.scan_done, out_ch.path_free, out_ch.target_found,
               out_ch.target_beam};
        board.check_report(got);
      end
      if (stall_request) begin
        hold_left     = 300;
        stall_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !out_gaps || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    logic [BEAM_W-1:0]  fb;
    logic [BEAM_W-1:0]  lb;
    logic [RANGE_W-1:0] thr;
    logic [RANGE_W-1:0] near;
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        beams;
    int unsigned        span;
    int unsigned        k;
    int unsigned        n;
    bit                 quiet;

    board = new;
    board.power_on();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_FIRST_BEAM;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.range_mm     <= '0;
    in_ch.last_in_scan <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default window, scan ends before it
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5AA5, 1'b1);

    // empty window
    drain_block();
    program_regs(10'd1023, 10'd0, 16'd0, 16'hFFFF);
    send_sample(16'hA55A, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'hFFFE, 1'b1);

    // full window, short scans leave capture pending
    drain_block();
    program_regs(10'd0, 10'd1023, 16'hFFFF, 16'd0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'd12345, 1'b1);
    drain_block();
    program_regs(10'd0, 10'd1023, 16'd100, 16'd500);
    send_sample(16'd500, 1'b0);
    send_sample(16'd499, 1'b1);
    send_sample(16'd501, 1'b1);

    // window at the top beam only
    drain_block();
    program_regs(10'd1023, 10'd1023, 16'd0, 16'hFFFF);
    send_sample(16'd7, 1'b1);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b1);

    // capture scan over the low beams, then a scan of changed beams
    drain_block();
    program_regs(10'd0, 10'd127, 16'd100, 16'd500);
    for (k = 0; k < 134; k++) begin
      if (k < 128) send_sample(RANGE_W'($urandom_range(65535)), k == 127);
      else send_sample(shifted(board.background_at(k - 128), 101 + $urandom_range(500)),
                       k == 133);
    end

    sent  = 0;
    phase = 0;
    while (sent < 620) begin
      drain_block();
      fb = BEAM_W'($urandom_range(40));
      lb = fb + BEAM_W'($urandom_range(40));
      case ($urandom_range(9))
        0: lb = 10'd1023;
        1: fb = 10'd1023;
        2: fb = 10'd0;
        3: fb = lb + BEAM_W'($urandom_range(1, 5));
        default: ;
      endcase
      case ($urandom_range(9))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = RANGE_W'($urandom_range(65535));
        default: thr = RANGE_W'($urandom_range(10, 400));
      endcase
      case ($urandom_range(9))
        0: near = 16'd0;
        1: near = 16'hFFFF;
        2: near = RANGE_W'($urandom_range(65535));
        default: near = RANGE_W'($urandom_range(4000));
      endcase
      program_regs(fb, lb, thr, near);
      quiet    = (phase % 4 == 1);
      in_gaps  = !quiet;
      out_gaps = !quiet;
      if (phase == 0 || phase == 3) stall_request = 1'b1;
      span = (fb <= lb) ? ((lb > 70) ? 70 : lb) : $urandom_range(30);
      n = $urandom_range(2, 5);
      for (k = 0; k < n; k++) begin
        beams = span + $urandom_range(1, 8);
        send_scan(beams, thr);
        sent += beams;
      end
      phase++;
    end

    drain_block();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** laser_scan_motion_target_core: PASSED **");
    end else begin
      $display("** laser_scan_motion_target_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lsmt_pkg.sv
rtl/lsmt_if.sv
rtl/laser_scan_motion_target_core.sv
rtl/lsmt_checker.sv
verif/testbench.sv
